/* hw/rtl/aiks_pkg.sv */
// ----------------------------------------------------------------------------
// aiks_pkg: shared types, constants and functions for the AES-128 inverse
// key schedule step.
// Holds the S-box table, the round constant decode and the SubWord(RotWord)
// helper used by the key step datapath.
// ----------------------------------------------------------------------------
package aiks_pkg;

  localparam int unsigned KeyHalfW = 64;
  localparam int unsigned RoundW   = 4;
  localparam int unsigned WordW    = 32;

  typedef logic [KeyHalfW-1:0] key_half_t;
  typedef logic [RoundW-1:0]   round_t;
  typedef logic [WordW-1:0]    word_t;
  typedef logic [7:0]          byte_t;

  localparam byte_t SBOX_TAB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t sbox(input byte_t b);
    return SBOX_TAB[b];
  endfunction

  // Round constant for rounds 0..9; other codes give zero.
  function automatic byte_t rcon(input round_t r);
    byte_t c;
    unique case (r)
      4'd0:    c = 8'h01;
      4'd1:    c = 8'h02;
      4'd2:    c = 8'h04;
      4'd3:    c = 8'h08;
      4'd4:    c = 8'h10;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h40;
      4'd7:    c = 8'h80;
      4'd8:    c = 8'h1b;
      4'd9:    c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic word_t sub_rot_word(input word_t w);
    return {sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
  endfunction

endpackage

/* hw/rtl/aiks_if.sv */
// ----------------------------------------------------------------------------
// aiks_if: valid/ready channels of the inverse key schedule step.
// aiks_in_if carries the next round key and round index, aiks_out_if the
// previous round key.
// ----------------------------------------------------------------------------
interface aiks_in_if;
  logic                valid;
  logic                ready;
  aiks_pkg::key_half_t key_hi;
  aiks_pkg::key_half_t key_lo;
  aiks_pkg::round_t    round_index;

  modport source (output valid, output key_hi, output key_lo, output round_index,
                  input ready);
  modport sink   (input valid, input key_hi, input key_lo, input round_index,
                  output ready);
endinterface

interface aiks_out_if;
  logic                valid;
  logic                ready;
  aiks_pkg::key_half_t prev_hi;
  aiks_pkg::key_half_t prev_lo;

  modport source (output valid, output prev_hi, output prev_lo, input ready);
  modport sink   (input valid, input prev_hi, input prev_lo, output ready);
endinterface

/* hw/rtl/aes128_inverse_key_schedule_step_top.sv */
// ----------------------------------------------------------------------------
// aes128_inverse_key_schedule_step_top: AES-128 inverse key schedule step.
// Takes round key r+1 with round index r and returns round key r.
// ----------------------------------------------------------------------------
// Usage:
//   in_key  (sink)   : one word per valid/ready handshake: key_hi, key_lo
//                      (byte 0 in key_hi[63:56]) and round_index 0..9.
//   out_key (source) : one word per input word: prev_hi, prev_lo in the
//                      same byte order. Indexes 10..15 use a zero rcon.
//   Two register stages: an input register and a result register, with the
//   XORs and four S-box lookups of word 0 between them. An accepted word
//   moves from the input register into the result register, which drives
//   out_key.valid, once the result register is free. One word is accepted
//   per cycle while the receiver does not stall.
//   Reset (rst_n low, synchronous) empties both stages and holds
//   in_key.ready low; in_key.ready rises as soon as rst_n is released.
//   When the receiver stalls, the result stage holds its word and the input
//   stage keeps filling; in_key.ready drops once both stages hold a word.
// ----------------------------------------------------------------------------
module aes128_inverse_key_schedule_step_top (
  input  logic       clk,
  input  logic       rst_n,
  aiks_in_if.sink    in_key,
  aiks_out_if.source out_key
);

  logic                s1_valid_r;
  aiks_pkg::key_half_t s1_hi_r;
  aiks_pkg::key_half_t s1_lo_r;
  aiks_pkg::round_t    s1_round_r;

  logic                s2_valid_r;
  aiks_pkg::key_half_t s2_hi_r;
  aiks_pkg::key_half_t s2_lo_r;

  logic                s2_load;
  logic                s1_load;

  aiks_pkg::word_t     n0, n1, n2, n3;
  aiks_pkg::word_t     p0, p1, p2, p3;

  assign s2_load = !s2_valid_r || out_key.ready;
  assign s1_load = !s1_valid_r || s2_load;

  // Hold off the sender while reset clears the stages.
  assign in_key.ready    = s1_load && rst_n;
  assign out_key.valid   = s2_valid_r;
  assign out_key.prev_hi = s2_hi_r;
  assign out_key.prev_lo = s2_lo_r;

  // Previous key words from the next key words.
  always_comb begin
    n0 = s1_hi_r[63:32];
    n1 = s1_hi_r[31:0];
    n2 = s1_lo_r[63:32];
    n3 = s1_lo_r[31:0];
    p1 = n1 ^ n0;
    p2 = n2 ^ n1;
    p3 = n3 ^ n2;
    p0 = n0 ^ aiks_pkg::sub_rot_word(p3) ^ {aiks_pkg::rcon(s1_round_r), 24'h000000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_key.valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_key.valid) begin
      s1_hi_r    <= in_key.key_hi;
      s1_lo_r    <= in_key.key_lo;
      s1_round_r <= in_key.round_index;
    end
    if (s2_load && s1_valid_r) begin
      s2_hi_r <= {p0, p1};
      s2_lo_r <= {p2, p3};
    end
  end

  // Reset empties both stages.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_key.valid)
    else $error("pipeline not empty after reset");

  // A word in the input stage moves on to the result stage when it may.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_load |=> out_key.valid)
    else $error("input stage word lost");

  // Words 1 and 3 of the result follow the input stage word.
  a_words: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_load |=>
      out_key.prev_hi[31:0] == ($past(s1_hi_r[63:32]) ^ $past(s1_hi_r[31:0])) &&
      out_key.prev_lo[31:0] == ($past(s1_lo_r[63:32]) ^ $past(s1_lo_r[31:0])))
    else $error("previous key word mismatch");

  // An empty input stage always takes a word.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_key.ready)
    else $error("input stalled while empty");

endmodule
